// ----- design/gbfs_pkg.sv -----
// Shared types, codes and constants of the grid breadth-first search block.
`default_nettype none

package gbfs_pkg;

	// Field widths of the item ports
	localparam int FW = 6;     // coordinate fields
	localparam int MW = 2;     // mode field
	localparam int RW = 7;     // area registers
	localparam int XW = 9;     // extended coordinate, holds any value up to 511

	// Grid size default
	localparam int MAX_DIM_DEF = 64;

	// Item modes
	localparam logic [MW-1:0] MODE_LOAD   = 2'd0;
	localparam logic [MW-1:0] MODE_SEARCH = 2'd1;
	localparam logic [MW-1:0] MODE_READ   = 2'd2;

	// Register indexes
	localparam logic REG_ROWS = 1'b0;
	localparam logic REG_COLS = 1'b1;
	localparam logic [RW-1:0] REG_RESET = 7'd64;

	// Neighbor order: up, down, left, right
	localparam logic [1:0] DIR_UP    = 2'd0;
	localparam logic [1:0] DIR_DOWN  = 2'd1;
	localparam logic [1:0] DIR_LEFT  = 2'd2;
	localparam logic [1:0] DIR_RIGHT = 2'd3;

	// Search epoch marks in the visit memory
	localparam int EPOCH_W = 8;
	localparam logic [EPOCH_W-1:0] EPOCH_FIRST = 8'd1;
	localparam logic [EPOCH_W-1:0] EPOCH_LAST  = 8'hFF;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_RDWAIT,
		ST_START,
		ST_POP,
		ST_NBR,
		ST_LAST,
		ST_DONE
	} gbfs_state_t;

endpackage

`default_nettype wire

// ----- design/grid_bfs_parent_map.sv -----
// Top level: grid map store and breadth-first search with parent marks.
//
//  channel | direction | handshake             | payload
//  --------+-----------+-----------------------+-----------------------------------------
//  in      | in        | in_valid / in_ready   | mode, row, col, goal_row, goal_col, open
//  out     | out       | out_valid / out_ready | found, visited, parent_row, parent_col
//  cfg     | in        | cfg_we                | cfg_index, cfg_data
//
// A load result is registered as the load is taken; a read waits for the registered visit
// memory read. A search runs a start write, one queue read, then four neighbor reads
// of the open and visit memories overlapped with the write-back of the previous neighbor,
// plus a further queue read state each time the queue runs dry at the end of a cell.
// After reset, and before every 255th search, a clearing pass writes MAX_DIM*MAX_DIM
// visit entries, one per cycle, during which no item is taken.
// A result waiting in the output register holds off the next input transfer; a result
// leaving in the same cycle does not.
`default_nettype none

module grid_bfs_parent_map import gbfs_pkg::*; #(
	parameter int MAX_DIM = MAX_DIM_DEF
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	// configuration
	input  wire logic          cfg_we,
	input  wire logic          cfg_index,
	input  wire logic [RW-1:0] cfg_data,
	// items
	input  wire logic          in_valid,
	output logic               in_ready,
	input  wire logic [MW-1:0] mode,
	input  wire logic [FW-1:0] row,
	input  wire logic [FW-1:0] col,
	input  wire logic [FW-1:0] goal_row,
	input  wire logic [FW-1:0] goal_col,
	input  wire logic          open,
	// results
	output logic               out_valid,
	input  wire logic          out_ready,
	output logic               found,
	output logic               visited,
	output logic [FW-1:0]      parent_row,
	output logic [FW-1:0]      parent_col
);

	localparam int CW    = $clog2(MAX_DIM);
	localparam int DEPTH = MAX_DIM * MAX_DIM;
	localparam int AW    = $clog2(DEPTH);
	localparam int VW    = EPOCH_W + 2 * CW;
	localparam int QW    = 2 * CW;
	localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);

	function automatic logic [AW-1:0] cell_addr(input logic [CW-1:0] r, input logic [CW-1:0] c);
		return AW'(r) * AW'(MAX_DIM) + AW'(c);
	endfunction

	function automatic logic [XW-1:0] area_limit(input logic [RW-1:0] v);
		logic [XW-1:0] e;
		e = XW'(v);
		return (e > XW'(MAX_DIM)) ? XW'(MAX_DIM) : e;
	endfunction

	gbfs_state_t state_q, state_d;

	logic [XW-1:0]      rows_lim_q, cols_lim_q;
	logic [EPOCH_W-1:0] epoch_q;
	logic               pend_q;
	logic [AW-1:0]      clr_q;
	logic [AW:0]        head_q, tail_q;
	logic [1:0]         k_q;
	logic [CW-1:0]      start_r_q, start_c_q;
	logic [XW-1:0]      goal_r_q, goal_c_q;
	logic               same_q, ok_q, inside_q, hit_q;
	logic [CW-1:0]      cur_r_q, cur_c_q;
	logic               out_valid_q, found_q, visited_q;
	logic [FW-1:0]      prow_q, pcol_q;
	logic               nv_s1;
	logic [AW-1:0]      naddr_s1;
	logic [CW-1:0]      nr_s1, nc_s1;

	// input decode
	logic          in_acc;
	logic [XW-1:0] row_x, col_x, grow_x, gcol_x;
	logic [CW-1:0] row_c, col_c;
	logic          inside_in;
	logic [AW-1:0] in_addr;

	assign in_acc    = in_valid && in_ready;
	assign row_x     = XW'(row);
	assign col_x     = XW'(col);
	assign grow_x    = XW'(goal_row);
	assign gcol_x    = XW'(goal_col);
	assign row_c     = row_x[CW-1:0];
	assign col_c     = col_x[CW-1:0];
	assign inside_in = (row_x < XW'(MAX_DIM)) && (col_x < XW'(MAX_DIM));
	assign in_addr   = cell_addr(row_c, col_c);

	// memories
	logic          open_we, open_rd;
	logic          vis_we;
	logic [AW-1:0] vis_waddr, vis_raddr;
	logic [VW-1:0] vis_wdata, vis_rdata;
	logic          q_we, q_re;
	logic [AW-1:0] q_waddr;
	logic [QW-1:0] q_wdata, q_rdata;
	logic [AW-1:0] naddr;

	gbfs_ram #(.WIDTH(1), .DEPTH(DEPTH)) u_open_ram (
		.clk   (clk),
		.we    (open_we),
		.waddr (in_addr),
		.wdata (open),
		.raddr (naddr),
		.rdata (open_rd)
	);

	gbfs_ram #(.WIDTH(VW), .DEPTH(DEPTH)) u_vis_ram (
		.clk   (clk),
		.we    (vis_we),
		.waddr (vis_waddr),
		.wdata (vis_wdata),
		.raddr (vis_raddr),
		.rdata (vis_rdata)
	);

	gbfs_ram #(.WIDTH(QW), .DEPTH(DEPTH)) u_queue_ram (
		.clk   (clk),
		.we    (q_we),
		.waddr (q_waddr),
		.wdata (q_wdata),
		.raddr (head_q[AW-1:0]),
		.rdata (q_rdata)
	);

	// visit entry fields
	logic [EPOCH_W-1:0] vis_tag;
	logic [CW-1:0]      vis_prow, vis_pcol;
	logic [XW-1:0]      vis_prow_x, vis_pcol_x;
	logic               vis_hit;

	assign vis_tag    = vis_rdata[VW-1 -: EPOCH_W];
	assign vis_prow   = vis_rdata[2*CW-1:CW];
	assign vis_pcol   = vis_rdata[CW-1:0];
	assign vis_prow_x = XW'(vis_prow);
	assign vis_pcol_x = XW'(vis_pcol);
	assign vis_hit    = inside_q && (vis_tag == epoch_q);

	// current cell and neighbor under test
	logic [CW-1:0] cur_r, cur_c;
	logic [XW-1:0] cur_r_x, cur_c_x, nr_x, nc_x;
	logic          nvalid, nbr_issue;
	logic [CW-1:0] nr_c, nc_c;

	assign cur_r   = (k_q == DIR_UP) ? q_rdata[QW-1:CW] : cur_r_q;
	assign cur_c   = (k_q == DIR_UP) ? q_rdata[CW-1:0]  : cur_c_q;
	assign cur_r_x = XW'(cur_r);
	assign cur_c_x = XW'(cur_c);

	always_comb begin
		nr_x   = cur_r_x;
		nc_x   = cur_c_x;
		nvalid = 1'b0;
		case (k_q)
			DIR_UP: begin
				nr_x   = cur_r_x - XW'(1);
				nvalid = (cur_r_x != '0);
			end
			DIR_DOWN: begin
				nr_x   = cur_r_x + XW'(1);
				nvalid = (nr_x < rows_lim_q);
			end
			DIR_LEFT: begin
				nc_x   = cur_c_x - XW'(1);
				nvalid = (cur_c_x != '0);
			end
			default: begin
				nc_x   = cur_c_x + XW'(1);
				nvalid = (nc_x < cols_lim_q);
			end
		endcase
	end

	assign nr_c      = nr_x[CW-1:0];
	assign nc_c      = nc_x[CW-1:0];
	assign naddr     = cell_addr(nr_c, nc_c);
	assign nbr_issue = (state_q == ST_NBR) && nvalid;

	// write-back of the neighbor read last cycle
	logic eval_en, take, hit;

	assign eval_en = nv_s1 && ((state_q == ST_NBR) || (state_q == ST_LAST));
	assign take    = eval_en && open_rd && (vis_tag != epoch_q);
	assign hit     = take && (XW'(nr_s1) == goal_r_q) && (XW'(nc_s1) == goal_c_q);

	// start cell checks
	logic start_ok_in;
	assign start_ok_in = inside_in && (row_x < rows_lim_q) && (col_x < cols_lim_q);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_CLEAR: begin
				if (clr_q == LAST_ADDR) begin
					state_d = pend_q ? ST_START : ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (in_acc) begin
					case (mode)
						MODE_SEARCH: state_d = (epoch_q == EPOCH_LAST) ? ST_CLEAR : ST_START;
						MODE_READ:   state_d = ST_RDWAIT;
						default:     state_d = ST_IDLE;
					endcase
				end
			end
			ST_RDWAIT: state_d = ST_IDLE;
			ST_START:  state_d = ok_q ? ST_POP : ST_DONE;
			ST_POP:    state_d = (head_q == tail_q) ? ST_DONE : ST_NBR;
			ST_NBR: begin
				if (hit) begin
					state_d = ST_DONE;
				end else if (k_q == DIR_RIGHT) begin
					state_d = ST_LAST;
				end
			end
			ST_LAST: begin
				if (hit) begin
					state_d = ST_DONE;
				end else if (head_q != tail_q) begin
					state_d = ST_NBR;
				end else begin
					state_d = ST_POP;
				end
			end
			ST_DONE:   state_d = ST_IDLE;
		endcase
	end

	// memory controls and handshake
	always_comb begin
		in_ready  = (state_q == ST_IDLE) && (!out_valid_q || out_ready);
		open_we   = in_acc && (mode == MODE_LOAD) && inside_in;
		vis_raddr = (state_q == ST_NBR) ? naddr : in_addr;
		vis_we    = 1'b0;
		vis_waddr = naddr_s1;
		vis_wdata = {epoch_q, cur_r_q, cur_c_q};
		q_we      = 1'b0;
		q_waddr   = tail_q[AW-1:0];
		q_wdata   = {nr_s1, nc_s1};
		q_re      = 1'b0;
		unique case (state_q)
			ST_CLEAR: begin
				vis_we    = 1'b1;
				vis_waddr = clr_q;
				vis_wdata = '0;
			end
			ST_START: begin
				vis_we    = ok_q;
				vis_waddr = cell_addr(start_r_q, start_c_q);
				vis_wdata = {epoch_q, {QW{1'b0}}};
				q_we      = ok_q;
				q_waddr   = '0;
				q_wdata   = {start_r_q, start_c_q};
			end
			ST_POP: begin
				q_re = (head_q != tail_q);
			end
			ST_NBR: begin
				vis_we = take;
				q_we   = take;
			end
			ST_LAST: begin
				vis_we = take;
				q_we   = take;
				q_re   = !hit && (head_q != tail_q);
			end
			default: begin
			end
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			rows_lim_q  <= area_limit(REG_RESET);
			cols_lim_q  <= area_limit(REG_RESET);
			epoch_q     <= EPOCH_FIRST;
			pend_q      <= 1'b0;
			clr_q       <= '0;
			head_q      <= '0;
			tail_q      <= '0;
			k_q         <= DIR_UP;
			hit_q       <= 1'b0;
			nv_s1       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			nv_s1   <= nbr_issue;

			// take register writes
			if (cfg_we) begin
				unique case (cfg_index)
					REG_ROWS: rows_lim_q <= area_limit(cfg_data);
					REG_COLS: cols_lim_q <= area_limit(cfg_data);
				endcase
			end

			// sweep the visit memory, rewind for the next pass
			if (state_q == ST_CLEAR) begin
				if (clr_q == LAST_ADDR) begin
					clr_q  <= '0;
					pend_q <= 1'b0;
				end else begin
					clr_q <= clr_q + AW'(1);
				end
			end

			// open a new search epoch
			if (in_acc && (mode == MODE_SEARCH)) begin
				if (epoch_q == EPOCH_LAST) begin
					epoch_q <= EPOCH_FIRST;
					pend_q  <= 1'b1;
				end else begin
					epoch_q <= epoch_q + EPOCH_W'(1);
				end
			end

			// queue pointers and neighbor step
			if (state_q == ST_START) begin
				head_q <= '0;
				tail_q <= (AW+1)'(1);
				hit_q  <= 1'b0;
				k_q    <= DIR_UP;
			end
			if (q_re) begin
				head_q <= head_q + (AW+1)'(1);
			end
			if (q_we && (state_q != ST_START)) begin
				tail_q <= tail_q + (AW+1)'(1);
			end
			if (hit) begin
				hit_q <= 1'b1;
			end
			if (state_q == ST_NBR) begin
				k_q <= k_q + 2'd1;
			end else if ((state_q == ST_POP) || (state_q == ST_LAST)) begin
				k_q <= DIR_UP;
			end

			// output valid: raise on a new result, drop on transfer
			if ((in_acc && (mode != MODE_SEARCH) && (mode != MODE_READ))
			    || (state_q == ST_RDWAIT) || (state_q == ST_DONE)) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (in_acc) begin
			start_r_q <= row_c;
			start_c_q <= col_c;
			goal_r_q  <= grow_x;
			goal_c_q  <= gcol_x;
			same_q    <= (row == goal_row) && (col == goal_col);
			ok_q      <= start_ok_in;
			inside_q  <= inside_in;
		end
		if ((state_q == ST_NBR) && (k_q == DIR_UP)) begin
			cur_r_q <= cur_r;
			cur_c_q <= cur_c;
		end
		if (nbr_issue) begin
			naddr_s1 <= naddr;
			nr_s1    <= nr_c;
			nc_s1    <= nc_c;
		end
		if (in_acc && (mode != MODE_SEARCH) && (mode != MODE_READ)) begin
			found_q   <= 1'b0;
			visited_q <= 1'b0;
			prow_q    <= '0;
			pcol_q    <= '0;
		end
		if (state_q == ST_RDWAIT) begin
			found_q   <= 1'b0;
			visited_q <= vis_hit;
			prow_q    <= vis_hit ? vis_prow_x[FW-1:0] : '0;
			pcol_q    <= vis_hit ? vis_pcol_x[FW-1:0] : '0;
		end
		if (state_q == ST_DONE) begin
			found_q   <= hit_q || same_q;
			visited_q <= 1'b0;
			prow_q    <= '0;
			pcol_q    <= '0;
		end
	end

	assign out_valid  = out_valid_q;
	assign found      = found_q;
	assign visited    = visited_q;
	assign parent_row = prow_q;
	assign parent_col = pcol_q;

	// queue head never passes the tail
	a_head_le_tail: assert property (@(posedge clk) disable iff (!arst_n)
		head_q <= tail_q)
		else $error("queue head ahead of tail");

	// visit write-back never hits the entry read in the same cycle
	a_vis_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		(vis_we && nbr_issue) |-> (vis_waddr != naddr))
		else $error("visit memory read and write on the same entry");

	// enqueue and dequeue never touch the same queue entry
	a_queue_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		(q_we && q_re) |-> (q_waddr != head_q[AW-1:0]))
		else $error("queue read and write on the same entry");

	// a result only enters an empty or draining output register
	a_out_free: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == ST_RDWAIT) || (state_q == ST_DONE)) |-> (!out_valid_q || out_ready))
		else $error("result overwrites a waiting result");

endmodule

`default_nettype wire

// ----- design/gbfs_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module gbfs_ram #(
	parameter int WIDTH = 1,
	parameter int DEPTH = 4
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Write one entry, register the read
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire
